// File: hdl/i2d_pkg.sv
// Shared types and constants for the integer to decimal ASCII converter.
package i2d_pkg;

	localparam int IN_VALUE_W = 32;
	localparam int CHAR_W     = 8;
	localparam int DIGIT_W    = 4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

	localparam logic OP_SIGNED   = 1'b0;
	localparam logic OP_UNSIGNED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} i2d_state_t;

	// status from the conversion unit
	typedef struct packed {
		logic busy;
		logic done;
	} i2d_stat_t;

endpackage

// File: hdl/i2d_in_if.sv
// Input request channel: word to convert and operation bit.
interface i2d_in_if import i2d_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [IN_VALUE_W-1:0] value;
	logic                  operation;

	modport source (output valid, output value, output operation, input ready);
	modport sink   (input valid, input value, input operation, output ready);
endinterface

// File: hdl/i2d_out_if.sv
// Output request channel: one ASCII character and an end-of-run flag.
interface i2d_out_if import i2d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

// File: hdl/integer_to_decimal_ascii.sv
// Top level: binary word to ASCII decimal character stream.
//
//  channel   dir   payload                          meaning
//  value_ch  in    value[31:0], operation           one word per request
//  char_ch   out   character[7:0], last             one character per request
//
// A word is loaded into the shift-and-add-3 unit and converted one bit per
// cycle, then its digit count is found; its characters then leave one per
// cycle while char_ch does not stall.
// value_ch.ready is high only while the sequencer is idle.
// char_ch is fed from an output register; a stall there holds the sequencer.
// Reset clears the sequencer and the output valid; data registers are not reset.
module integer_to_decimal_ascii import i2d_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	i2d_in_if.sink        value_ch,
	i2d_out_if.source     char_ch
);

	// enough decimal digits for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10 2)
	localparam int NUM_DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	i2d_state_t state_q, state_n;

	logic [VALUE_WIDTH-1:0]        word;
	logic [VALUE_WIDTH-1:0]        magnitude;
	logic                          negative;
	logic                          neg_q;
	logic                          accept;
	i2d_stat_t                     stat;
	logic [NUM_DIGITS*DIGIT_W-1:0] bcd;
	logic [IDX_W-1:0]              msd;
	logic [IDX_W-1:0]              idx_q;
	logic [DIGIT_W-1:0]            digit;

	// output register
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              slot_free;
	logic              push;
	logic [CHAR_W-1:0] push_char;
	logic              push_last;

	// word of VALUE_WIDTH bits from the 32-bit field
	generate
		if (VALUE_WIDTH <= IN_VALUE_W) begin : g_narrow
			assign word = value_ch.value[VALUE_WIDTH-1:0];
		end else begin : g_wide
			assign word = {{(VALUE_WIDTH-IN_VALUE_W){1'b0}}, value_ch.value};
		end
	endgenerate

	assign negative  = (value_ch.operation == OP_SIGNED) && word[VALUE_WIDTH-1];
	// most negative word wraps to 2^(VALUE_WIDTH-1), as wanted
	assign magnitude = negative ? (~word + VALUE_WIDTH'(1)) : word;

	assign value_ch.ready = (state_q == ST_IDLE);
	assign accept         = value_ch.valid && value_ch.ready;
	assign slot_free      = !out_valid_q || char_ch.ready;
	assign digit          = bcd[idx_q*DIGIT_W +: DIGIT_W];

	i2d_dabble #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_DIGITS  (NUM_DIGITS),
		.IDX_W       (IDX_W)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.magnitude (magnitude),
		.stat      (stat),
		.bcd       (bcd),
		.msd       (msd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// sequencer: wait for the digits, then the sign if negative, then digits most significant first
	always_comb begin
		state_n   = state_q;
		push      = 1'b0;
		push_char = CH_ZERO;
		push_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_n = ST_CONV;
				end
			end
			ST_CONV: begin
				if (stat.done) begin
					state_n = neg_q ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					push      = 1'b1;
					push_char = CH_MINUS;
					state_n   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					push      = 1'b1;
					push_char = CH_ZERO + CHAR_W'(digit);
					push_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= negative;
		end
		if (state_q == ST_CONV && stat.done) begin
			idx_q <= msd;
		end else if (state_q == ST_EMIT && push && idx_q != '0) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && push) begin
			char_q <= push_char;
			last_q <= push_last;
		end
	end

	assign char_ch.valid     = out_valid_q;
	assign char_ch.character = char_q;
	assign char_ch.last      = last_q;

endmodule

// File: hdl/i2d_dabble.sv
// Iterative shift-and-add-3 binary to BCD unit, one bit per cycle.
module i2d_dabble import i2d_pkg::*; #(
	parameter int VALUE_WIDTH = 32,
	parameter int NUM_DIGITS  = 10,
	parameter int IDX_W       = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        magnitude,
	output i2d_stat_t                     stat,
	output logic [NUM_DIGITS*DIGIT_W-1:0] bcd,
	output logic [IDX_W-1:0]              msd
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0]        bin_q;
	logic [NUM_DIGITS*DIGIT_W-1:0] bcd_q;
	logic [NUM_DIGITS*DIGIT_W-1:0] adj;
	logic [CNT_W-1:0]              cnt_q;
	logic                          run_q;
	logic                          done_q;
	logic [IDX_W-1:0]              msd_q;
	logic [IDX_W-1:0]              msd_n;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (bcd_q[k*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adj[k*DIGIT_W +: DIGIT_W] = bcd_q[k*DIGIT_W +: DIGIT_W];
			end
		end
	end

	// highest nonzero digit; zero gives index 0
	always_comb begin
		msd_n = '0;
		for (int k = 0; k < NUM_DIGITS; k++) begin
			if (bcd_q[k*DIGIT_W +: DIGIT_W] != '0) begin
				msd_n = IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_WIDTH);
			end else if (run_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= magnitude;
			bcd_q <= '0;
		end else if (run_q && cnt_q != '0) begin
			bcd_q <= {adj[NUM_DIGITS*DIGIT_W-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
		end
		if (run_q && cnt_q == '0) begin
			msd_q <= msd_n;
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign bcd       = bcd_q;
	assign msd       = msd_q;

endmodule

// File: hdl/i2d_checker.sv
// Port-level checks for the converter and their bind to the top level.
module i2d_checker import i2d_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after a request was taken");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_char == CH_MINUS || (out_char >= CH_ZERO && out_char <= CH_NINE))
		else $error("illegal output character");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char == CH_MINUS |-> !out_last)
		else $error("minus sign flagged as last");

endmodule

bind integer_to_decimal_ascii i2d_checker u_i2d_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (value_ch.valid),
	.in_ready  (value_ch.ready),
	.out_valid (char_ch.valid),
	.out_ready (char_ch.ready),
	.out_char  (char_ch.character),
	.out_last  (char_ch.last)
);

// File: sim/tb_integer_to_decimal_ascii.sv
// Self-checking testbench for the integer to decimal ASCII converter.
module tb_integer_to_decimal_ascii import i2d_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RADIX        = 10;
	localparam int MAX_REPORTED = 10;
	localparam int RANDOM_WORDS = 260;
	localparam int HOLD_AFTER   = 120;	// words accepted before the long receiver hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 60;	// > one full conversion at 32 bits

	// One expected character of a run.
	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} ascii_char_t;

	// Predicts the character run of each accepted word and checks every
	// character that leaves the block against the oldest prediction.
	class decimal_text_board;
		ascii_char_t pending_chars[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction

		// Build the run for one word: optional minus sign, then the
		// magnitude most significant digit first, no leading zeros.
		function void note_word(logic [IN_VALUE_W-1:0] word, logic op);
			logic [IN_VALUE_W-1:0] magnitude;
			logic [DIGIT_W-1:0]    digits[$];
			ascii_char_t           c;
			magnitude = word;
			if (op == OP_SIGNED && word[IN_VALUE_W-1]) begin
				c.character = CH_MINUS;
				c.last      = 1'b0;
				pending_chars.push_back(c);
				// two's complement negate; the most negative word maps onto itself,
				// which read unsigned is its true magnitude
				magnitude = -word;
			end
			do begin
				digits.push_front(DIGIT_W'(magnitude % RADIX));
				magnitude = magnitude / RADIX;
			end while (magnitude != 0);
			foreach (digits[i]) begin
				c.character = CH_ZERO + CHAR_W'(digits[i]);
				c.last      = (i == digits.size() - 1);
				pending_chars.push_back(c);
			end
		endfunction

		function void check_char(logic [CHAR_W-1:0] character, logic last);
			ascii_char_t exp_c;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("%0t: character %h last %b arrived with nothing pending",
						$realtime, character, last);
				return;
			end
			exp_c = pending_chars.pop_front();
			if (exp_c.character !== character || exp_c.last !== last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("%0t: expected char %h last %b, got char %h last %b",
						$realtime, exp_c.character, exp_c.last, character, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	i2d_in_if  value_ch ();
	i2d_out_if char_ch ();

	integer_to_decimal_ascii DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.value_ch (value_ch.sink),
		.char_ch  (char_ch.source)
	);

	decimal_text_board board = new();

	int   words_accepted = 0;
	logic rx_hold;		// long receiver hold-off, driven by its own process
	int   stall_phase;
	int   stall_mode;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Safety net: far beyond the slowest legal run (~280 words, each converted and
	// then sent as up to 11 heavily stalled characters, plus a gap).
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Present one word and wait until the block takes it. valid is left high
	// so back-to-back requests need no extra edge; the caller lowers it.
	task automatic send_word(logic [IN_VALUE_W-1:0] word, logic op);
		value_ch.valid     <= 1'b1;
		value_ch.value     <= word;
		value_ch.operation <= op;
		do @(posedge clk); while (!value_ch.ready);
		board.note_word(word, op);
		words_accepted++;
	endtask

	task automatic idle_sender(int cycles);
		value_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Sender holds off until every predicted character has been seen.
	task automatic wait_all_chars();
		value_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Random word, weighted toward digit-count boundaries and sign extremes.
	function automatic logic [IN_VALUE_W-1:0] pick_word();
		logic [IN_VALUE_W-1:0] pow;
		int                    k;
		pow = 1;
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, RADIX - 1);
			1: return $urandom_range(0, 99999);
			2: begin
				// power of ten, one below, or one above
				k = $urandom_range(0, 9);
				repeat (k) pow = pow * RADIX;
				return pow + $urandom_range(0, 2) - 1;
			end
			3: return -$urandom_range(1, 1000);
			4: return {1'b1, {(IN_VALUE_W-1){1'b0}}} + $urandom_range(0, 3) - 1;
			5: return ~$urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Output side: check every accepted character, then pick ready for the
	// next edge. stall_mode, redrawn at random, picks the pattern: always
	// ready, mostly ready, a fixed two-of-three duty or mostly stalled.
	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready)
			board.check_char(char_ch.character, char_ch.last);
		stall_phase <= stall_phase + 1;
		if (stall_phase % 64 == 63)
			stall_mode <= $urandom_range(0, 3);
		if (rx_hold)
			char_ch.ready <= 1'b0;
		else begin
			case (stall_mode)
				0: char_ch.ready <= 1'b1;
				1: char_ch.ready <= ($urandom_range(0, 9) < 7);
				2: char_ch.ready <= (stall_phase % 3 != 0);
				default: char_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Long receiver hold-off in the middle of the random part: the block
	// fills, its output backs up and the input channel must stall.
	initial begin
		rx_hold = 1'b0;
		while (words_accepted < HOLD_AFTER) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Reset and stimulus.
	initial begin
		int burst;
		arst_n              = 1'b0;
		stall_phase         = 0;
		stall_mode          = 0;
		value_ch.valid      = 1'b0;
		value_ch.value      = '0;
		value_ch.operation  = OP_SIGNED;
		char_ch.ready       = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero both ways, digit-count boundaries, sign extremes,
		// all-ones read both ways, alternating bit patterns.
		send_word(32'd0,          OP_SIGNED);
		send_word(32'd0,          OP_UNSIGNED);
		send_word(32'd1,          OP_SIGNED);
		send_word(32'd9,          OP_UNSIGNED);
		send_word(32'd10,         OP_SIGNED);
		send_word(32'd99,         OP_UNSIGNED);
		send_word(32'd100,        OP_SIGNED);
		idle_sender(3);
		send_word(32'd999999999,  OP_UNSIGNED);
		send_word(32'd1000000000, OP_SIGNED);
		send_word(32'h7fff_ffff,  OP_SIGNED);
		send_word(32'h7fff_ffff,  OP_UNSIGNED);
		// most negative signed word: magnitude is 2^31
		send_word(32'h8000_0000,  OP_SIGNED);
		send_word(32'h8000_0000,  OP_UNSIGNED);
		send_word(32'h8000_0001,  OP_SIGNED);
		idle_sender(1);
		send_word(32'hffff_ffff,  OP_SIGNED);
		send_word(32'hffff_ffff,  OP_UNSIGNED);
		send_word(32'hffff_fff6,  OP_SIGNED);
		send_word(32'hffff_fff6,  OP_UNSIGNED);
		send_word(32'haaaa_aaaa,  OP_SIGNED);
		send_word(32'haaaa_aaaa,  OP_UNSIGNED);
		send_word(32'h5555_5555,  OP_SIGNED);
		send_word(32'h5555_5555,  OP_UNSIGNED);
		// sender pause: let the whole directed set drain
		wait_all_chars();

		// Random part in bursts with random gaps; some bursts run back to back.
		while (words_accepted < RANDOM_WORDS + 22) begin
			burst = $urandom_range(1, 12);
			repeat (burst) send_word(pick_word(), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 20));
		end

		wait_all_chars();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
